@@ rtl/dbsd_pkg.sv @@
`default_nettype none

package dbsd_pkg;

    localparam int CELL_W = 32;

    localparam logic [1:0] OP_UNSIGNED = 2'd0;
    localparam logic [1:0] OP_SYMMETRIC = 2'd1;
    localparam logic [1:0] OP_FLOORED = 2'd2;

    // Operands and partial results that travel down the divide pipeline.
    typedef struct packed {
        logic [1:0]        mode;
        logic              neg_dvd;
        logic              neg_dvs;
        logic              ovf;
        logic [CELL_W-1:0] dv;
        logic [CELL_W-1:0] md;
        logic [CELL_W-1:0] rem;
        logic [CELL_W-1:0] acc;
    } work_t;

endpackage

`default_nettype wire

@@ rtl/dbsd_step.sv @@
`default_nettype none

module dbsd_step (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            advance,
    input  logic            in_valid,
    input  dbsd_pkg::work_t in_work,
    output logic            out_valid,
    output dbsd_pkg::work_t out_work
);
    import dbsd_pkg::*;

    logic [CELL_W:0]   trial;
    logic [CELL_W+1:0] diff;
    logic              take;
    work_t             work_next;
    work_t             work_reg;
    logic              valid_reg;

    // One restoring step: the partial remainder takes the next dividend bit
    // from the top of acc, and the quotient bit shifts in at its bottom.
    always_comb
    begin
        trial = {in_work.rem, in_work.acc[CELL_W-1]};
        diff = {1'b0, trial} - {2'b00, in_work.md};
        take = ~diff[CELL_W+1];
        work_next = in_work;
        work_next.rem = take ? diff[CELL_W-1:0] : trial[CELL_W-1:0];
        work_next.acc = {in_work.acc[CELL_W-2:0], take};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            work_reg <= work_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_work = work_reg;

endmodule

`default_nettype wire

@@ rtl/double_by_single_divider_core.sv @@
`default_nettype none

// Double-cell by single-cell divider, pipelined.
// Input channel s_axis: tdata carries the dividend high cell, the dividend low
// cell and the divisor; tuser carries the mode (unsigned, symmetric signed or
// floored signed; the unused code divides unsigned).
// Output channel m_axis: tdata carries quotient and remainder, tuser the
// overflow flag. On overflow, which includes a zero divisor, quotient and
// remainder are zero.
// From the accepting edge to the result on m_axis, one stage forms magnitudes, one
// checks for overflow, 32 stages each produce one quotient bit with a 33-bit
// subtract, and two stages fix signs.
// Throughput is one item per cycle when not stalled; items are independent.
// Reset empties the pipeline; results in flight are dropped.
// When the receiver holds m_axis_tready low while a result is shown, the whole
// pipeline freezes and s_axis_tready falls in the same cycle; nothing is lost
// or repeated, and bubbles are not squeezed out but travel down with the results.
module double_by_single_divider_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // dividend_high [31:0], dividend_low [63:32], divisor_value [95:64]
    input  logic [95:0] s_axis_tdata,
    // opcode [1:0]
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // quotient [31:0], remainder [63:32]
    output logic [63:0] m_axis_tdata,
    // overflow [0]
    output logic        m_axis_tuser
);
    import dbsd_pkg::*;

    localparam int STEPS = CELL_W;

    logic              advance;
    logic [CELL_W-1:0] in_hi;
    logic [CELL_W-1:0] in_lo;
    logic [CELL_W-1:0] in_dv;
    logic              in_signed;
    work_t             prep_next;
    work_t             prep_reg;
    logic              prep_valid_reg;
    work_t             chk_next;
    work_t             chk_reg;
    logic              chk_valid_reg;

    logic              step_valid [STEPS+1];
    work_t             step_work [STEPS+1];

    work_t             fin_work;
    logic              fix_next;
    logic [CELL_W-1:0] q1_next;
    logic [CELL_W-1:0] r1_next;
    logic              p1_valid_reg;
    logic              p1_ovf_reg;
    logic              p1_fix_reg;
    logic [1:0]        p1_mode_reg;
    logic [CELL_W-1:0] p1_dv_reg;
    logic [CELL_W-1:0] p1_q_reg;
    logic [CELL_W-1:0] p1_r_reg;
    logic [CELL_W-1:0] q2_next;
    logic [CELL_W-1:0] r2_next;
    logic              p2_valid_reg;
    logic              p2_ovf_reg;
    logic [1:0]        p2_mode_reg;
    logic [CELL_W-1:0] p2_dv_reg;
    logic [CELL_W-1:0] p2_q_reg;
    logic [CELL_W-1:0] p2_r_reg;

    assign advance = ~p2_valid_reg | m_axis_tready;
    assign s_axis_tready = advance;

    assign in_hi = s_axis_tdata[CELL_W-1:0];
    assign in_lo = s_axis_tdata[2*CELL_W-1:CELL_W];
    assign in_dv = s_axis_tdata[3*CELL_W-1:2*CELL_W];

    // Magnitudes of dividend and divisor in the signed modes.
    always_comb
    begin
        in_signed = (s_axis_tuser == OP_SYMMETRIC) || (s_axis_tuser == OP_FLOORED);
        prep_next = '0;
        prep_next.mode = s_axis_tuser;
        prep_next.neg_dvd = in_signed & in_hi[CELL_W-1];
        prep_next.neg_dvs = in_signed & in_dv[CELL_W-1];
        prep_next.dv = in_dv;
        prep_next.md = prep_next.neg_dvs ? (~in_dv + 1'b1) : in_dv;
        prep_next.rem = in_hi;
        prep_next.acc = in_lo;
        if (prep_next.neg_dvd)
        begin
            if (in_lo != '0)
            begin
                prep_next.acc = ~in_lo + 1'b1;
                prep_next.rem = ~in_hi;
            end
            else
            begin
                prep_next.rem = ~in_hi + 1'b1;
            end
        end
    end

    // The quotient fits only when the high cell is below the divisor.
    always_comb
    begin
        chk_next = prep_reg;
        chk_next.ovf = ~(prep_reg.rem < prep_reg.md);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prep_valid_reg <= 1'b0;
            chk_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            prep_valid_reg <= s_axis_tvalid;
            chk_valid_reg <= prep_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            prep_reg <= prep_next;
            chk_reg <= chk_next;
        end
    end

    assign step_valid[0] = chk_valid_reg;
    assign step_work[0] = chk_reg;

    for (genvar i = 0; i < STEPS; i++)
    begin : g_step
        dbsd_step u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .advance   (advance),
            .in_valid  (step_valid[i]),
            .in_work   (step_work[i]),
            .out_valid (step_valid[i+1]),
            .out_work  (step_work[i+1])
        );
    end

    assign fin_work = step_work[STEPS];

    // Sign fixes; the floored adjustment is left for the last stage.
    always_comb
    begin
        q1_next = fin_work.acc;
        r1_next = fin_work.rem;
        fix_next = 1'b0;
        unique case (fin_work.mode)
            OP_SYMMETRIC:
            begin
                if (fin_work.neg_dvd != fin_work.neg_dvs)
                begin
                    q1_next = ~fin_work.acc + 1'b1;
                end
                if (fin_work.neg_dvd)
                begin
                    r1_next = ~fin_work.rem + 1'b1;
                end
            end
            OP_FLOORED:
            begin
                if (fin_work.neg_dvs)
                begin
                    r1_next = ~fin_work.rem + 1'b1;
                end
                if (fin_work.neg_dvd != fin_work.neg_dvs)
                begin
                    q1_next = ~fin_work.acc + 1'b1;
                    fix_next = (fin_work.rem != '0);
                end
            end
            default:
            begin
                q1_next = fin_work.acc;
            end
        endcase
    end

    always_comb
    begin
        q2_next = p1_q_reg;
        r2_next = p1_r_reg;
        if (p1_ovf_reg)
        begin
            q2_next = '0;
            r2_next = '0;
        end
        else if (p1_fix_reg)
        begin
            q2_next = p1_q_reg - 1'b1;
            r2_next = p1_dv_reg - p1_r_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            p1_valid_reg <= step_valid[STEPS];
            p2_valid_reg <= p1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            p1_ovf_reg <= fin_work.ovf;
            p1_fix_reg <= fix_next;
            p1_mode_reg <= fin_work.mode;
            p1_dv_reg <= fin_work.dv;
            p1_q_reg <= q1_next;
            p1_r_reg <= r1_next;
            p2_ovf_reg <= p1_ovf_reg;
            p2_mode_reg <= p1_mode_reg;
            p2_dv_reg <= p1_dv_reg;
            p2_q_reg <= q2_next;
            p2_r_reg <= r2_next;
        end
    end

    assign m_axis_tvalid = p2_valid_reg;
    assign m_axis_tdata = {p2_r_reg, p2_q_reg};
    assign m_axis_tuser = p2_ovf_reg;

    // An overflowed division reports zero quotient and remainder.
    a_ovf_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
        else $error("overflow result carries nonzero data");

    // Without overflow the partial remainder stays below the divisor magnitude.
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        step_valid[STEPS] && !fin_work.ovf |-> fin_work.rem < fin_work.md)
        else $error("partial remainder not below divisor");

    // An unsigned result has a remainder below the divisor.
    a_unsigned_rem: assert property (@(posedge clk) disable iff (!rst_n)
        p2_valid_reg && !p2_ovf_reg && p2_mode_reg == OP_UNSIGNED
        |-> p2_r_reg < p2_dv_reg)
        else $error("unsigned remainder not below divisor");

    // A frozen pipeline keeps the shown result.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(p2_q_reg) && $stable(p2_r_reg) && p2_valid_reg)
        else $error("result changed while stalled");

endmodule

`default_nettype wire

@@ tb/sv/dbsd_result_checker.sv @@
`default_nettype none

module dbsd_result_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    input  wire logic        s_axis_tready,
    input  wire logic [95:0] s_axis_tdata,
    input  wire logic [1:0]  s_axis_tuser,
    input  wire logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    input  wire logic [63:0] m_axis_tdata,
    input  wire logic        m_axis_tuser,
    output int               fail_count,
    output int               outstanding
);

    timeunit 1ns;
    timeprecision 1ps;

    import dbsd_pkg::*;

    typedef struct packed {
        logic [CELL_W-1:0] quotient;
        logic [CELL_W-1:0] remainder;
        logic              overflow;
    } quot_rem_t;

    quot_rem_t pending_quotients[$];

    initial
    begin
        fail_count = 0;
        outstanding = 0;
    end

    function automatic quot_rem_t predict_division(logic [1:0] mode, logic [CELL_W-1:0] hi,
                                                   logic [CELL_W-1:0] lo,
                                                   logic [CELL_W-1:0] dv);
        logic                signed_mode;
        logic                neg_dvd;
        logic                neg_dvs;
        logic [2*CELL_W-1:0] mag_dvd;
        logic [CELL_W-1:0]   mag_dvs;
        logic [2*CELL_W-1:0] quo_wide;
        logic [2*CELL_W-1:0] rem_wide;
        logic [CELL_W-1:0]   q;
        logic [CELL_W-1:0]   r;
        quot_rem_t           res;
        signed_mode = (mode == OP_SYMMETRIC) || (mode == OP_FLOORED);
        neg_dvd = signed_mode && hi[CELL_W-1];
        neg_dvs = signed_mode && dv[CELL_W-1];
        mag_dvd = neg_dvd ? (64'd0 - {hi, lo}) : {hi, lo};
        mag_dvs = neg_dvs ? (32'd0 - dv) : dv;
        res = '0;
        // A high cell at or above the divisor would not give a one-cell
        // quotient; a zero divisor always lands here.
        if (mag_dvd[2*CELL_W-1:CELL_W] >= mag_dvs)
        begin
            res.overflow = 1'b1;
            return res;
        end
        quo_wide = mag_dvd / {32'd0, mag_dvs};
        rem_wide = mag_dvd % {32'd0, mag_dvs};
        q = quo_wide[CELL_W-1:0];
        r = rem_wide[CELL_W-1:0];
        if (mode == OP_SYMMETRIC)
        begin
            if (neg_dvd != neg_dvs)
                q = 32'd0 - q;
            if (neg_dvd)
                r = 32'd0 - r;
        end
        else if (mode == OP_FLOORED)
        begin
            if (neg_dvs)
                r = 32'd0 - r;
            if (neg_dvd != neg_dvs)
            begin
                q = 32'd0 - q;
                if (r != 0)
                begin
                    q = q - 32'd1;
                    r = dv - r;
                end
            end
        end
        res.quotient = q;
        res.remainder = r;
        return res;
    endfunction

    always @(posedge clk)
    begin
        quot_rem_t want;
        quot_rem_t got;
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
                pending_quotients.push_back(predict_division(s_axis_tuser,
                    s_axis_tdata[31:0], s_axis_tdata[63:32], s_axis_tdata[95:64]));
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = {m_axis_tdata[31:0], m_axis_tdata[63:32], m_axis_tuser};
                if (pending_quotients.size() == 0)
                begin
                    fail_count = fail_count + 1;
                    $display("%0t: unexpected item: expected none, actual q=%h r=%h ovf=%b",
                             $time, got.quotient, got.remainder, got.overflow);
                end
                else
                begin
                    want = pending_quotients.pop_front();
                    if (got !== want)
                    begin
                        fail_count = fail_count + 1;
                        $display({"%0t: mismatch: expected q=%h r=%h ovf=%b,",
                                  " actual q=%h r=%h ovf=%b"}, $time,
                                 want.quotient, want.remainder, want.overflow,
                                 got.quotient, got.remainder, got.overflow);
                    end
                end
            end
            outstanding = pending_quotients.size();
        end
    end

endmodule

`default_nettype wire

@@ tb/sv/tb_double_by_single_divider_core.sv @@
`default_nettype none

module tb_double_by_single_divider_core;

    import dbsd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // The fourth mode code has no meaning of its own and divides unsigned.
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam int RANDOM_PER_PHASE = 443;
    localparam int RECV_HOLD_CYCLES = 200;
    localparam int DRAIN_CYCLES = 60;
    localparam int WATCHDOG_LIMIT = 5000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [95:0] s_axis_tdata = '0;
    logic [1:0]  s_axis_tuser = OP_UNSIGNED;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;
    logic        m_axis_tuser;

    int fail_count;
    int outstanding;
    int send_idle_pct = 18;
    int recv_idle_pct = 65;
    int stall_cycles = 0;
    bit hold_request = 1'b0;

    double_by_single_divider_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    dbsd_result_checker u_result_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .fail_count    (fail_count),
        .outstanding   (outstanding)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    task automatic send_division(logic [1:0] mode, logic [31:0] hi, logic [31:0] lo,
                                 logic [31:0] dv);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= mode;
        s_axis_tdata <= {dv, lo, hi};
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    function automatic logic [31:0] corner_or_random();
        case ($urandom_range(0, 7))
            0: return 32'h0000_0000;
            1: return 32'h0000_0001;
            2: return 32'h7FFF_FFFF;
            3: return 32'h8000_0000;
            4: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // Receiver side: random stalls, plus one long hold-off on request so the
    // pipeline fills and pushes back on the sender.
    initial begin
        forever begin
            @(posedge clk);
            if (hold_request) begin
                m_axis_tready <= 1'b0;
                repeat (RECV_HOLD_CYCLES) @(posedge clk);
                hold_request = 1'b0;
            end
            m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("FAIL double_by_single_divider_core");
                $finish;
            end
        end
    end

    initial begin
        logic [1:0]  mode;
        logic        signed_mode;
        logic [31:0] dv;
        logic [31:0] dv_mag;
        logic [31:0] hi_mag;
        logic [63:0] dividend;
        int          pick;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_division(OP_UNSIGNED, 32'h0000_0000, 32'h0000_0064, 32'h0000_0007);
        send_division(OP_UNSIGNED, 32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_division(OP_UNSIGNED, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001);
        send_division(OP_UNSIGNED, 32'h0000_0000, 32'h0000_0000, 32'h0000_0001);
        send_division(OP_UNSIGNED, 32'h0000_0000, 32'h1234_5678, 32'h0000_0000);
        send_division(OP_SYMMETRIC, 32'h0000_0000, 32'h0000_0005, 32'h0000_0000);
        send_division(OP_FLOORED, 32'hFFFF_FFFF, 32'hFFFF_FFFB, 32'h0000_0000);
        send_division(OP_UNSIGNED, 32'h0000_1000, 32'h0000_0000, 32'h0000_1000);
        send_division(OP_UNUSED, 32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        // Seven by two with each sign combination that has a negative, in both signed modes.
        send_division(OP_SYMMETRIC, 32'hFFFF_FFFF, 32'hFFFF_FFF9, 32'h0000_0002);
        send_division(OP_SYMMETRIC, 32'h0000_0000, 32'h0000_0007, 32'hFFFF_FFFE);
        send_division(OP_SYMMETRIC, 32'hFFFF_FFFF, 32'hFFFF_FFF9, 32'hFFFF_FFFE);
        send_division(OP_FLOORED, 32'hFFFF_FFFF, 32'hFFFF_FFF9, 32'h0000_0002);
        send_division(OP_FLOORED, 32'h0000_0000, 32'h0000_0007, 32'hFFFF_FFFE);
        send_division(OP_FLOORED, 32'hFFFF_FFFF, 32'hFFFF_FFF9, 32'hFFFF_FFFE);
        // Exact negative division leaves no remainder to fold.
        send_division(OP_FLOORED, 32'hFFFF_FFFF, 32'hFFFF_FFF8, 32'h0000_0002);
        send_division(OP_SYMMETRIC, 32'h0000_0000, 32'h0000_0064, 32'h8000_0000);
        send_division(OP_FLOORED, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000);
        send_division(OP_SYMMETRIC, 32'h8000_0000, 32'h0000_0000, 32'h7FFF_FFFF);
        send_division(OP_FLOORED, 32'h8000_0000, 32'h0000_0000, 32'h8000_0000);
        // Quotient too big for a signed cell wraps.
        send_division(OP_SYMMETRIC, 32'h3FFF_FFFF, 32'h0000_0000, 32'h4000_0000);
        send_division(OP_FLOORED, 32'hFFFF_FFFE, 32'h0000_0000, 32'h0000_0005);
        send_division(OP_SYMMETRIC, 32'hFFFF_FFFE, 32'h0000_0000, 32'hFFFF_FFFB);

        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 18 : (phase == 1) ? 65 : 0;
            recv_idle_pct = (phase == 0) ? 65 : (phase == 1) ? 18 : 0;
            for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
                if (phase == 2 && i == RANDOM_PER_PHASE / 3)
                    hold_request = 1'b1;
                pick = $urandom_range(0, 15);
                mode = (pick < 5) ? OP_UNSIGNED : (pick < 10) ? OP_SYMMETRIC :
                       (pick < 15) ? OP_FLOORED : OP_UNUSED;
                if ($urandom_range(0, 3) == 0) begin
                    send_division(mode, corner_or_random(), corner_or_random(),
                                  corner_or_random());
                end else begin
                    // Well-formed division: the dividend's high magnitude stays
                    // below the divisor magnitude so a real quotient comes out.
                    signed_mode = (mode == OP_SYMMETRIC) || (mode == OP_FLOORED);
                    dv = $urandom >> $urandom_range(0, 31);
                    if ($urandom_range(0, 1))
                        dv = 32'd0 - dv;
                    dv_mag = (signed_mode && dv[31]) ? (32'd0 - dv) : dv;
                    if (dv_mag == 0) begin
                        dv = 32'd1;
                        dv_mag = 32'd1;
                    end
                    case ($urandom_range(0, 5))
                        0: hi_mag = 32'd0;
                        1: hi_mag = dv_mag - 32'd1;
                        default: hi_mag = $urandom % dv_mag;
                    endcase
                    dividend = {hi_mag, 32'($urandom)};
                    if (signed_mode && $urandom_range(0, 1))
                        dividend = 64'd0 - dividend;
                    send_division(mode, dividend[63:32], dividend[31:0], dv);
                end
            end
        end
        s_axis_tvalid <= 1'b0;

        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("PASS double_by_single_divider_core");
        else
            $display("FAIL double_by_single_divider_core");
        $finish;
    end

endmodule

`default_nettype wire
